// ===== rtl/core/srl_pkg.sv =====
// ----------------------------------------------------------------------------
// srl_pkg
// Shared codes and types for the slope ratio limiter: limiter mode codes and
// the result select carried along the pipeline.
// ----------------------------------------------------------------------------
package srl_pkg;

  localparam int unsigned ModeW = 2;

  localparam logic [ModeW-1:0] MODE_MINMOD = 2'd0;
  localparam logic [ModeW-1:0] MODE_ALBADA = 2'd1;
  localparam logic [ModeW-1:0] MODE_RESET  = 2'd3;

  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_MINMOD,
    SEL_ALBADA
  } res_sel_e;

endpackage

// ===== rtl/core/slope_ratio_limiter_unit.sv =====
// ----------------------------------------------------------------------------
// slope_ratio_limiter_unit
// TVD slope limiter, minmod or van Albada, on one gradient pair per request.
// Throughput: one request per cycle while in_stall_o is low, set by the
// bit-per-stage divider pipe.
// Reset: asynchronous, clears valids and sets the limiter mode to 3 (zero).
// ----------------------------------------------------------------------------
module slope_ratio_limiter_unit #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [1:0]                   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [DATA_WIDTH-1:0] grad_left_i,
  input  logic signed [DATA_WIDTH-1:0] grad_right_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [DATA_WIDTH-1:0] limited_grad_o
);

  import srl_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int LW = DATA_WIDTH / 2;
  localparam int HW = DATA_WIDTH - LW;

  typedef struct packed {
    res_sel_e     sel;
    logic         neg;
    logic [W-1:0] mm;
  } tag_t;

  localparam int TagW = $bits(tag_t);

  logic [ModeW-1:0] mode_q;
  logic             en;

  // config register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= cfg_data_i;
    end
  end

  // stage 1: magnitudes
  logic [W-1:0] a_in, b_in, ma1_d, mb1_d;
  logic         v1_q;
  logic [W-1:0] a1_q, b1_q, ma1_q, mb1_q;
  logic         na1_q, nb1_q;

  always_comb begin
    a_in  = grad_left_i;
    b_in  = grad_right_i;
    ma1_d = a_in[W-1] ? -a_in : a_in;
    mb1_d = b_in[W-1] ? -b_in : b_in;
  end

  // stage 2: select, minmod, partial products
  tag_t          tag2_d;
  logic [W:0]    t2_d;
  logic [LW-1:0] ml, nl;
  logic [HW-1:0] mh, nh;
  logic          v2_q;
  tag_t          tag2_q;
  logic [W:0]    t2_q;
  logic [2*LW-1:0] pll_q, sml_q, snl_q;
  logic [W-1:0]    plh_q, phl_q, smx_q, snx_q;
  logic [2*HW-1:0] phh_q, smh_q, snh_q;

  always_comb begin
    ml = ma1_q[LW-1:0];
    mh = ma1_q[W-1:LW];
    nl = mb1_q[LW-1:0];
    nh = mb1_q[W-1:LW];
    t2_d = {1'b0, ma1_q} + {1'b0, mb1_q};
    tag2_d.neg = na1_q;
    tag2_d.mm  = (ma1_q < mb1_q) ? a1_q : b1_q;
    priority if (a1_q == '0 || b1_q == '0 || na1_q != nb1_q) begin
      tag2_d.sel = SEL_ZERO;
    end else if (mode_q == MODE_MINMOD) begin
      tag2_d.sel = SEL_MINMOD;
    end else if (mode_q == MODE_ALBADA) begin
      tag2_d.sel = SEL_ALBADA;
    end else begin
      tag2_d.sel = SEL_ZERO;
    end
  end

  // stage 3: product and squares
  logic [2*W-1:0] p3_d, msq3_d, nsq3_d;
  logic           v3_q;
  tag_t           tag3_q;
  logic [W:0]     t3_q;
  logic [2*W-1:0] p3_q, msq3_q, nsq3_q;

  always_comb begin
    p3_d   = ((2*W)'(phh_q) << (2*LW)) + (((2*W)'(plh_q) + (2*W)'(phl_q)) << LW)
           + (2*W)'(pll_q);
    msq3_d = ((2*W)'(smh_q) << (2*LW)) + ((2*W)'(smx_q) << (LW+1)) + (2*W)'(sml_q);
    nsq3_d = ((2*W)'(snh_q) << (2*LW)) + ((2*W)'(snx_q) << (LW+1)) + (2*W)'(snl_q);
  end

  // stage 4: denominator
  logic           v4_q;
  tag_t           tag4_q;
  logic [W:0]     t4_q;
  logic [2*W-1:0] p4_q, d4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_q   <= a_in;
      b1_q   <= b_in;
      ma1_q  <= ma1_d;
      mb1_q  <= mb1_d;
      na1_q  <= a_in[W-1];
      nb1_q  <= b_in[W-1];
      tag2_q <= tag2_d;
      t2_q   <= t2_d;
      pll_q  <= (2*LW)'(ml) * (2*LW)'(nl);
      plh_q  <= W'(ml) * W'(nh);
      phl_q  <= W'(mh) * W'(nl);
      phh_q  <= (2*HW)'(mh) * (2*HW)'(nh);
      sml_q  <= (2*LW)'(ml) * (2*LW)'(ml);
      smx_q  <= W'(ml) * W'(mh);
      smh_q  <= (2*HW)'(mh) * (2*HW)'(mh);
      snl_q  <= (2*LW)'(nl) * (2*LW)'(nl);
      snx_q  <= W'(nl) * W'(nh);
      snh_q  <= (2*HW)'(nh) * (2*HW)'(nh);
      tag3_q <= tag2_q;
      t3_q   <= t2_q;
      p3_q   <= p3_d;
      msq3_q <= msq3_d;
      nsq3_q <= nsq3_d;
      tag4_q <= tag3_q;
      t4_q   <= t3_q;
      p4_q   <= p3_q;
      d4_q   <= msq3_q + nsq3_q;
    end
  end

  // van albada quotient
  logic            div_valid;
  logic [W-1:0]    div_quot;
  logic [TagW-1:0] div_tag;
  tag_t            fin_tag;
  logic [W-1:0]    fin_res_d;

  srl_div_pipe #(
    .DATA_WIDTH (DATA_WIDTH),
    .TAG_W      (TagW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v4_q),
    .prod_i  (p4_q),
    .den_i   (d4_q),
    .sum_i   (t4_q),
    .tag_i   (tag4_q),
    .valid_o (div_valid),
    .quot_o  (div_quot),
    .tag_o   (div_tag)
  );

  always_comb begin
    fin_tag = div_tag;
    unique case (fin_tag.sel)
      SEL_MINMOD: fin_res_d = fin_tag.mm;
      SEL_ALBADA: fin_res_d = fin_tag.neg ? -div_quot : div_quot;
      SEL_ZERO:   fin_res_d = '0;
      default:    fin_res_d = '0;
    endcase
  end

  // output register with skid stage
  logic         out_valid_q, skid_valid_q;
  logic [W-1:0] out_data_q, skid_data_q;

  assign en = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (!out_stall_i) begin
        skid_valid_q <= 1'b0;
      end
    end else if (out_valid_q && out_stall_i) begin
      skid_valid_q <= div_valid;
    end else begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (!out_stall_i) begin
        out_data_q <= skid_data_q;
      end
    end else if (out_valid_q && out_stall_i) begin
      skid_data_q <= fin_res_d;
    end else begin
      out_data_q <= fin_res_d;
    end
  end

  assign in_stall_o     = skid_valid_q;
  assign out_valid_o    = out_valid_q;
  assign limited_grad_o = out_data_q;

endmodule

// ===== rtl/core/srl_div_pipe.sv =====
// ----------------------------------------------------------------------------
// srl_div_pipe
// Pipelined multiply-divide: floor(prod * sum / den), one bit of sum per
// stage from the top, remainder kept below den, quotient digit 0, 1 or 2.
// Requires prod <= den / 2. A side tag travels with each request.
// ----------------------------------------------------------------------------
module srl_div_pipe #(
  parameter int DATA_WIDTH = 32,
  parameter int TAG_W      = 35
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [2*DATA_WIDTH-1:0] prod_i,
  input  logic [2*DATA_WIDTH-1:0] den_i,
  input  logic [DATA_WIDTH:0]     sum_i,
  input  logic [TAG_W-1:0]        tag_i,
  output logic                    valid_o,
  output logic [DATA_WIDTH-1:0]   quot_o,
  output logic [TAG_W-1:0]        tag_o
);

  localparam int W  = DATA_WIDTH;
  localparam int RW = 2 * DATA_WIDTH;

  logic          v_q   [0:W];
  logic [RW-1:0] r_q   [0:W];
  logic [W-1:0]  quo_q [0:W];
  logic [RW-1:0] p_q   [0:W];
  logic [RW-1:0] d_q   [0:W];
  logic [W:0]    t_q   [0:W];
  logic [TAG_W-1:0] tag_q [0:W];

  for (genvar j = 0; j <= W; j++) begin : g_stage
    logic          v_in;
    logic [RW-1:0] r_in;
    logic [W-1:0]  quo_in;
    logic [RW-1:0] p_in;
    logic [RW-1:0] d_in;
    logic [W:0]    t_in;
    logic [TAG_W-1:0] tag_in;
    logic [RW:0]   s;
    logic [RW:0]   d1;
    logic [RW:0]   d2;
    logic [RW:0]   s_m1;
    logic [RW:0]   s_m2;
    logic [1:0]    dig;
    logic [RW-1:0] r_d;
    logic [W:0]    quo_sum;
    logic [W-1:0]  quo_d;

    if (j == 0) begin : g_first
      assign v_in   = valid_i;
      assign r_in   = '0;
      assign quo_in = '0;
      assign p_in   = prod_i;
      assign d_in   = den_i;
      assign t_in   = sum_i;
      assign tag_in = tag_i;
    end else begin : g_next
      assign v_in   = v_q[j-1];
      assign r_in   = r_q[j-1];
      assign quo_in = quo_q[j-1];
      assign p_in   = p_q[j-1];
      assign d_in   = d_q[j-1];
      assign t_in   = t_q[j-1];
      assign tag_in = tag_q[j-1];
    end

    always_comb begin
      s    = {r_in, 1'b0} + (t_in[W-j] ? {1'b0, p_in} : '0);
      d1   = {1'b0, d_in};
      d2   = {d_in, 1'b0};
      s_m1 = s - d1;
      s_m2 = s - d2;
      priority if (s >= d2) begin
        r_d = s_m2[RW-1:0];
        dig = 2'd2;
      end else if (s >= d1) begin
        r_d = s_m1[RW-1:0];
        dig = 2'd1;
      end else begin
        r_d = s[RW-1:0];
        dig = 2'd0;
      end
      quo_sum = {quo_in, 1'b0} + {{(W-1){1'b0}}, dig};
      quo_d   = quo_sum[W-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[j]   <= r_d;
        quo_q[j] <= quo_d;
        p_q[j]   <= p_in;
        d_q[j]   <= d_in;
        t_q[j]   <= t_in;
        tag_q[j] <= tag_in;
      end
    end
  end

  assign valid_o = v_q[W];
  assign quot_o  = quo_q[W];
  assign tag_o   = tag_q[W];

endmodule

// ===== rtl/core/srl_checker.sv =====
// ----------------------------------------------------------------------------
// srl_checker
// Port-level checks for the slope ratio limiter: skid stage behavior, output
// hold under stall and zero results in the unused limiter modes.
// ----------------------------------------------------------------------------
module srl_checker #(
  parameter int DATA_WIDTH = 32
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         cfg_valid_i,
  input logic                         cfg_ready_o,
  input logic [1:0]                   cfg_data_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic signed [DATA_WIDTH-1:0] limited_grad_o
);

  import srl_pkg::*;

  logic [ModeW-1:0] mode_q;

  // shadow of the limiter mode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= cfg_data_i;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(limited_grad_o))
    else $error("result changed while stalled");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && !out_stall_i |=> !in_stall_o)
    else $error("skid stage did not drain");

  a_zero_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_q != MODE_MINMOD && mode_q != MODE_ALBADA
      |-> limited_grad_o == '0)
    else $error("nonzero result in unused mode");

endmodule

bind slope_ratio_limiter_unit srl_checker #(.DATA_WIDTH(DATA_WIDTH)) u_srl_checker (.*);

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for slope_ratio_limiter_unit. A short table of gradient
// pairs walks every limiter mode, the sign and zero cases and the Q16.16
// extremes. Random pairs follow, mostly same-sign pairs that reach the
// limiter math. Each accepted pair is predicted by a behavioral limiter
// unless its table row holds the value, and each returned gradient is
// checked in order under varying idle and stall traffic on both sides.
// ----------------------------------------------------------------------------
module tb;
  import srl_pkg::*;

  localparam int W = 32;
  localparam logic [ModeW-1:0] MODE_UNUSED = 2'd2;
  localparam logic [W-1:0] GRAD_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] GRAD_MAX = {1'b0, {(W-1){1'b1}}};
  localparam int PHASE_ITEMS = 188;
  localparam int NUM_ROWS = 23;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [W-1:0]     left;
    logic [W-1:0]     right;
    logic             known;
    logic [W-1:0]     value;
  } pair_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_data = MODE_RESET;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic signed [W-1:0] grad_left = '0;
  logic signed [W-1:0] grad_right = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic signed [W-1:0] limited_grad;

  logic [ModeW-1:0]    active_mode = MODE_RESET;
  logic [W-1:0]        expected_grads [$];
  int                  mismatch_count = 0;
  int                  idle_pct = 0;
  int                  stall_pct = 0;
  pair_row_t           directed_rows [0:NUM_ROWS-1];

  slope_ratio_limiter_unit #(
    .DATA_WIDTH(W)
  ) uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .grad_left_i   (grad_left),
    .grad_right_i  (grad_right),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .limited_grad_o(limited_grad)
  );

  always #10 clk = ~clk;

  function automatic logic [W-1:0] limit_slope(input logic [ModeW-1:0] mode,
                                                input logic [W-1:0] a,
                                                input logic [W-1:0] b);
    logic [W-1:0]   mag_a;
    logic [W-1:0]   mag_b;
    logic [4*W-1:0] m;
    logic [4*W-1:0] n;
    logic [4*W-1:0] quo;
    logic [W-1:0]   q;
    mag_a = a[W-1] ? -a : a;
    mag_b = b[W-1] ? -b : b;
    if (a == '0 || b == '0 || a[W-1] != b[W-1]) begin
      return '0;
    end
    case (mode)
      MODE_MINMOD: begin
        return (mag_a < mag_b) ? a : b;
      end
      MODE_ALBADA: begin
        m = (4*W)'(mag_a);
        n = (4*W)'(mag_b);
        quo = (m * n * (m + n)) / (m * m + n * n);
        q = quo[W-1:0];
        return a[W-1] ? -q : q;
      end
      default: begin
        return '0;
      end
    endcase
  endfunction

  function automatic logic [W-1:0] rand_grad(input bit neg);
    logic [W-1:0] mag;
    if (neg && $urandom_range(0, 31) == 0) begin
      return GRAD_MIN;
    end
    mag = $urandom >> $urandom_range(0, 30);
    mag[W-1] = 1'b0;
    if (mag == '0) begin
      mag = W'(1);
    end
    return neg ? -mag : mag;
  endfunction

  function automatic logic [W-1:0] rand_extreme();
    case ($urandom_range(0, 4))
      0: return GRAD_MIN;
      1: return GRAD_MAX;
      2: return W'(1);
      3: return '1;
      default: return GRAD_MIN + W'(1);
    endcase
  endfunction

  // receiver stall
  always @(negedge clk) begin
    out_stall = (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    logic [W-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_grads.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected limited_grad %0d, none expected", $time, limited_grad);
      end else begin
        want = expected_grads.pop_front();
        if (limited_grad !== want) begin
          mismatch_count++;
          $display("%0t: limited_grad expected %0d got %0d", $time, $signed(want),
                   limited_grad);
        end
      end
    end
  end

  task automatic write_mode(input logic [ModeW-1:0] mode);
    while (expected_grads.size() != 0) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = mode;
    do @(posedge clk); while (!cfg_ready);
    active_mode = mode;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic feed_pair(input logic [W-1:0] left, input logic [W-1:0] right,
                           input logic known, input logic [W-1:0] value);
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    grad_left = left;
    grad_right = right;
    do @(posedge clk); while (in_stall);
    expected_grads.push_back(known ? value : limit_slope(active_mode, left, right));
    @(negedge clk);
  endtask

  initial begin
    logic [ModeW-1:0] phase_modes [0:7];
    logic [W-1:0]     left;
    logic [W-1:0]     right;
    bit               neg;

    directed_rows = '{
      '{MODE_RESET,  32'h0005_0000, 32'h0003_0000, 1'b1, 32'h0},
      '{MODE_RESET,  GRAD_MIN,      GRAD_MIN,      1'b1, 32'h0},
      '{MODE_MINMOD, 32'h0,         32'h7,         1'b1, 32'h0},
      '{MODE_MINMOD, 32'h7,         32'h0,         1'b1, 32'h0},
      '{MODE_MINMOD, 32'h5,         32'hFFFF_FFFD, 1'b1, 32'h0},
      '{MODE_MINMOD, 32'h0001_0000, 32'h0003_0000, 1'b1, 32'h0001_0000},
      '{MODE_MINMOD, 32'hFFFE_0000, 32'hFFFE_0000, 1'b1, 32'hFFFE_0000},
      '{MODE_MINMOD, GRAD_MAX,      GRAD_MAX,      1'b1, GRAD_MAX},
      '{MODE_MINMOD, GRAD_MIN,      GRAD_MIN,      1'b1, GRAD_MIN},
      '{MODE_MINMOD, GRAD_MIN,      32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
      '{MODE_MINMOD, 32'h1,         GRAD_MAX,      1'b1, 32'h1},
      '{MODE_MINMOD, 32'h0005_0000, 32'h0002_0000, 1'b1, 32'h0002_0000},
      '{MODE_ALBADA, GRAD_MIN,      GRAD_MIN,      1'b1, GRAD_MIN},
      '{MODE_ALBADA, 32'h0001_0000, 32'h0001_0000, 1'b1, 32'h0001_0000},
      '{MODE_ALBADA, GRAD_MAX,      GRAD_MAX,      1'b1, GRAD_MAX},
      '{MODE_ALBADA, 32'h1,         GRAD_MAX,      1'b0, 32'h0},
      '{MODE_ALBADA, 32'hFFFF_FFFF, GRAD_MIN,      1'b0, 32'h0},
      '{MODE_ALBADA, 32'h0,         32'h5,         1'b1, 32'h0},
      '{MODE_ALBADA, 32'hFFFF_FFFB, 32'h5,         1'b1, 32'h0},
      '{MODE_ALBADA, 32'h0003_0000, 32'h0001_0000, 1'b0, 32'h0},
      '{MODE_ALBADA, 32'hFFFD_0000, 32'hFFF9_0000, 1'b0, 32'h0},
      '{MODE_UNUSED, 32'h0001_0000, 32'h0001_0000, 1'b1, 32'h0},
      '{MODE_UNUSED, GRAD_MIN,      GRAD_MIN,      1'b1, 32'h0}
    };
    phase_modes = '{MODE_ALBADA, MODE_MINMOD, MODE_ALBADA, MODE_RESET,
                    MODE_MINMOD, MODE_ALBADA, MODE_UNUSED, MODE_MINMOD};

    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int i = 0; i < NUM_ROWS; i++) begin
      if (directed_rows[i].mode != active_mode) begin
        in_valid = 1'b0;
        write_mode(directed_rows[i].mode);
      end
      feed_pair(directed_rows[i].left, directed_rows[i].right,
                directed_rows[i].known, directed_rows[i].value);
    end

    for (int phase = 0; phase < 8; phase++) begin
      in_valid = 1'b0;
      write_mode(phase_modes[phase]);
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 81; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 81; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        neg = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 15))
          0: begin
            left = $urandom_range(0, 1) ? '0 : $urandom;
            right = (left == '0) ? $urandom : '0;
          end
          1: begin
            left = rand_grad(neg);
            right = rand_grad(!neg);
          end
          2: begin
            left = rand_extreme();
            right = rand_extreme();
          end
          3: begin
            left = $urandom;
            right = $urandom;
          end
          4: begin
            left = rand_grad(neg);
            right = left;
          end
          default: begin
            left = rand_grad(neg);
            right = rand_grad(neg);
          end
        endcase
        feed_pair(left, right, 1'b0, '0);
      end
    end
    in_valid = 1'b0;

    while (expected_grads.size() != 0) @(negedge clk);
    repeat (W + 8) @(negedge clk);
    if (mismatch_count == 0 && expected_grads.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
